### design/cqce_pkg.sv
// ----------------------------------------------------------------------------
// cqce_pkg: shared types and constants
// Phase codes, result and bundle types, character and register codes used by
// the quoted column extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqce_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ColW   = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned SlotN  = 3;

  localparam logic [CharW-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CharW-1:0] CH_COMMA = 16'h002C;
  localparam logic [CharW-1:0] CH_SPACE = 16'h0020;
  localparam logic [CharW-1:0] CH_TAB   = 16'h0009;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_FORMAT   = 2'd1;
  localparam logic [StatW-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_COLUMN_INDEX = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH   = 8'd1;

  localparam logic RK_CHAR   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_BEFORE = 7'b0000010,
    PH_FIELD  = 7'b0000100,
    PH_QUOTE  = 7'b0001000,
    PH_AFTER  = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] chr;
    logic             line_end;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] out_char;
    logic [StatW-1:0] status;
  } result_t;

  typedef struct packed {
    result_t [SlotN-1:0] slot;
    logic [1:0]          count;
  } bundle_t;

endpackage

### design/cqce_in_reg.sv
// ----------------------------------------------------------------------------
// cqce_in_reg: input register
// Holds one accepted character until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqce_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cqce_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              take_i,
  output cqce_pkg::in_item_t item_o
);
  import cqce_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

### design/cqce_parse.sv
// ----------------------------------------------------------------------------
// cqce_parse: line parser
// Per character, advances the field phase and builds the bundle of results
// (up to two content characters and the line status).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqce_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  cqce_pkg::in_item_t            item_i,
  input  logic [cqce_pkg::ColW-1:0]     column_index_i,
  input  logic [cqce_pkg::LenW-1:0]     max_length_i,
  output cqce_pkg::bundle_t             bundle_o
);
  import cqce_pkg::*;

  phase_e            phase_q, phase_d;
  logic [ColW-1:0]   cols_q, cols_d;
  logic [LenW-1:0]   count_q, count_d;
  logic [StatW-1:0]  err_q, err_d;

  logic              is_quote, is_comma, is_blank;
  logic              emit0, emit1;
  logic [CharW-1:0]  ch0;
  logic [1:0]        n_chr;
  logic [StatW-1:0]  st;
  logic [LenW:0]     count_inc;
  result_t           stat_res;

  assign is_quote  = (item_i.chr == CH_QUOTE);
  assign is_comma  = (item_i.chr == CH_COMMA);
  assign is_blank  = (item_i.chr == CH_SPACE) || (item_i.chr == CH_TAB);
  assign count_inc = {1'b0, count_q} + {{LenW{1'b0}}, 1'b1};

  always_comb begin
    phase_d = phase_q;
    cols_d  = cols_q;
    err_d   = err_q;
    emit0   = 1'b0;
    emit1   = 1'b0;
    ch0     = item_i.chr;
    st      = ST_FORMAT;

    // first character of a line loads the column countdown
    if (phase_q == PH_IDLE) begin
      cols_d  = column_index_i;
      phase_d = PH_BEFORE;
    end

    case (phase_d)
      PH_BEFORE: begin
        if (is_quote) begin
          phase_d = PH_FIELD;
        end else if (!is_blank) begin
          phase_d = PH_ERROR;
        end
      end
      PH_FIELD: begin
        if (is_quote) begin
          phase_d = PH_QUOTE;
        end else if (cols_d == '0) begin
          if (count_q >= max_length_i) begin
            err_d = ST_OVERFLOW;
          end else begin
            emit0 = 1'b1;
          end
        end
      end
      PH_QUOTE: begin
        if (is_quote) begin
          // doubled quote: emit both quotes as content
          phase_d = PH_FIELD;
          ch0     = CH_QUOTE;
          if (cols_d == '0) begin
            if (count_q >= max_length_i) begin
              err_d = ST_OVERFLOW;
            end else begin
              emit0 = 1'b1;
              if (count_inc >= {1'b0, max_length_i}) begin
                err_d = ST_OVERFLOW;
              end else begin
                emit1 = 1'b1;
              end
            end
          end
        end else if (cols_d == '0) begin
          phase_d = PH_DONE;
        end else if (!is_blank) begin
          if (is_comma) begin
            cols_d  = cols_d - 1'b1;
            phase_d = PH_BEFORE;
          end else begin
            phase_d = PH_ERROR;
          end
        end else begin
          phase_d = PH_AFTER;
        end
      end
      PH_AFTER: begin
        if (!is_blank) begin
          if (is_comma && cols_d != '0) begin
            cols_d  = cols_d - 1'b1;
            phase_d = PH_BEFORE;
          end else begin
            phase_d = PH_ERROR;
          end
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase

    count_d = count_q + {{(LenW-1){1'b0}}, emit0} + {{(LenW-1){1'b0}}, emit1};

    if (phase_d == PH_DONE || (phase_d == PH_QUOTE && cols_d == '0)) begin
      st = err_d;
    end

    if (item_i.line_end) begin
      phase_d = PH_IDLE;
      cols_d  = column_index_i;
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  // pack content results first, status after them
  always_comb begin
    n_chr = emit1 ? 2'd2 : (emit0 ? 2'd1 : 2'd0);
    stat_res = '{kind: RK_STATUS, out_char: '0, status: st};
    bundle_o.slot[0] = '{kind: RK_CHAR, out_char: ch0, status: ST_OK};
    bundle_o.slot[1] = '{kind: RK_CHAR, out_char: CH_QUOTE, status: ST_OK};
    bundle_o.slot[2] = '0;
    bundle_o.count   = n_chr;
    if (item_i.line_end) begin
      bundle_o.count = n_chr + 2'd1;
      case (n_chr)
        2'd0:    bundle_o.slot[0] = stat_res;
        2'd1:    bundle_o.slot[1] = stat_res;
        default: bundle_o.slot[2] = stat_res;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cols_q  <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      cols_q  <= cols_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

endmodule

### design/cqce_out_ser.sv
// ----------------------------------------------------------------------------
// cqce_out_ser: result register and serializer
// Holds one bundle of results and hands them out one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqce_out_ser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cqce_pkg::bundle_t bundle_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output cqce_pkg::result_t result_o,
  output logic              last_o
);
  import cqce_pkg::*;

  result_t [SlotN-1:0] slot_q;
  logic [1:0]          rem_q, rem_d;
  logic [1:0]          idx_q, idx_d;

  assign valid_o = (rem_q != 2'd0);
  assign last_o  = (rem_q == 2'd1);
  // take a new bundle when empty or once the last pending result is leaving
  assign free_o  = (rem_q == 2'd0) || (rem_q == 2'd1 && ready_i);

  always_comb begin
    case (idx_q)
      2'd0:    result_o = slot_q[0];
      2'd1:    result_o = slot_q[1];
      default: result_o = slot_q[2];
    endcase
  end

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load_i) begin
      rem_d = bundle_i.count;
      idx_d = 2'd0;
    end else if (valid_o && ready_i) begin
      rem_d = rem_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
  end

endmodule

### design/csv_quoted_column_extractor.sv
// ----------------------------------------------------------------------------
// csv_quoted_column_extractor: quoted CSV column extractor
// Streams one line of 16-bit characters and returns the selected column.
// ----------------------------------------------------------------------------
// One character is taken per clock while each character yields at most one
// result and the output is not stalled; a result leaves on every output
// transfer. A doubled quote inside the selected column yields two content
// results and the last character of a line adds a status result, so such a
// character holds the input while the output serializer drains its results.
// Results pass through the input register, then the result register. Output
// tdata carries out_char in bits 15:0 and status in bits 17:16; tuser is the
// kind (0 content, 1 status) and tlast marks the last result of a character.
// Registers: index 0 column_index, index 1 max_length; write them only
// between lines.
`timescale 1ns / 1ps

module csv_quoted_column_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] chr
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] out_char, [17:16] status
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import cqce_pkg::*;

  logic [ColW-1:0] column_index_q;
  logic [LenW-1:0] max_length_q;

  in_item_t in_item, cur_item;
  logic     cur_valid, ser_free, step;
  bundle_t  bundle;
  result_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_index_q <= '0;
      max_length_q   <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLUMN_INDEX: column_index_q <= cfg_data_i[ColW-1:0];
        CFG_MAX_LENGTH:   max_length_q   <= cfg_data_i[LenW-1:0];
        default:          ;
      endcase
    end
  end

  assign in_item = '{chr: s_axis_tdata, line_end: s_axis_tlast};
  assign step    = cur_valid && ser_free;

  cqce_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (step),
    .item_o  (cur_item)
  );

  cqce_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (cur_item),
    .column_index_i (column_index_q),
    .max_length_i   (max_length_q),
    .bundle_o       (bundle)
  );

  cqce_out_ser u_out_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .bundle_i (bundle),
    .free_o   (ser_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, res.status, res.out_char};
  assign m_axis_tuser = res.kind;

endmodule
